@@ sv/assert_macros.svh @@
// assertion macros used by the rtl file photo_position_tracker_core.sv
// no dependencies; simulation gets the checks, synthesis gets empty bodies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// concurrent check on the rising clock edge, off while reset is low
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// condition that must never be true at a rising clock edge
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    `ASSERT_CLK(label, clk, rst_n, !(cond), msg)

`else

`define ASSERT_CLK(label, clk, rst_n, prop, msg)

`define ASSERT_NEVER(label, clk, rst_n, cond, msg)

`endif

`endif

@@ sv/ppt_pkg.sv @@
// package of the photo position tracker: widths, register indexes, types
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package ppt_pkg;

    localparam int PPT_QUEUE_SLOTS = 16;

    localparam int W_POS   = 16;
    localparam int W_HIGH  = 13;
    localparam int W_QCNT  = 4;
    localparam int W_CONF  = 9;
    localparam int W_FILT  = 8;
    localparam int W_LOCK  = 10;
    localparam int W_CIDX  = 3;
    localparam int W_CDATA = 16;

    localparam logic [W_HIGH-1:0] HIGH_TIME_MAX = 13'd5000;

    typedef logic [W_CIDX-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_COUNT_FILTER  = 3'd0;
    localparam t_cfg_idx CFG_RESET_FILTER  = 3'd1;
    localparam t_cfg_idx CFG_LOCKOUT_TICKS = 3'd2;
    localparam t_cfg_idx CFG_MAX_POSITION  = 3'd3;
    localparam t_cfg_idx CFG_SYSTEM_ENABLE = 3'd4;

    // debounce state of one sensor
    typedef struct packed {
        logic              stable;
        logic              candidate;
        logic [W_CONF-1:0] confirm;
        logic [W_HIGH-1:0] high;
    } t_deb;

    typedef struct packed {
        t_deb st;
        logic rise;
    } t_deb_out;

    // one result word
    typedef struct packed {
        logic              entry_valid;
        logic [W_POS-1:0]  entry_position;
        logic [W_POS-1:0]  entry_interval;
        logic [W_POS-1:0]  position;
        logic              homed;
        logic [W_POS-1:0]  lost_resets;
        logic [W_HIGH-1:0] reset_high_time;
        logic [W_HIGH-1:0] count_high_time;
        logic              dropped;
        logic [W_QCNT-1:0] queue_count;
    } t_result;

endpackage

`default_nettype wire

@@ sv/ppt_ifs.sv @@
// channel interfaces of the photo position tracker: item, result, config write
// depends on ppt_pkg
`timescale 1ns / 1ps
`default_nettype none

interface ppt_item_if import ppt_pkg::*; ();
    logic valid;
    logic ready;
    logic kind;
    logic reset_pin;
    logic count_pin;

    modport source (output valid, kind, reset_pin, count_pin, input ready);
    modport sink   (input valid, kind, reset_pin, count_pin, output ready);
endinterface

interface ppt_result_if import ppt_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              entry_valid;
    logic [W_POS-1:0]  entry_position;
    logic [W_POS-1:0]  entry_interval;
    logic [W_POS-1:0]  position;
    logic              homed;
    logic [W_POS-1:0]  lost_resets;
    logic [W_HIGH-1:0] reset_high_time;
    logic [W_HIGH-1:0] count_high_time;
    logic              dropped;
    logic [W_QCNT-1:0] queue_count;

    modport source (output valid, entry_valid, entry_position, entry_interval, position,
                    homed, lost_resets, reset_high_time, count_high_time, dropped,
                    queue_count, input ready);
    modport sink   (input valid, entry_valid, entry_position, entry_interval, position,
                    homed, lost_resets, reset_high_time, count_high_time, dropped,
                    queue_count, output ready);
endinterface

interface ppt_cfg_if import ppt_pkg::*; ();
    logic               valid;
    logic               ready;
    t_cfg_idx           index;
    logic [W_CDATA-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ sv/ppt_ram.sv @@
// generic single write port, single read port ram with registered read data
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module ppt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

@@ sv/photo_position_tracker_core.sv @@
// top level of the photo position tracker: debounce, position logic, entry queue
// depends on ppt_pkg, ppt_ifs, ppt_ram and assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

// Photo position tracker. Every input word is either a sensor tick (kind 0),
// which debounces the reset and count sensor levels and updates position,
// homed, lost-reset count and high-time counters, or a read (kind 1), which
// pops the oldest {interval, position} entry from a ring queue held in a
// QUEUE_SLOTS deep ram (one slot always kept empty, so QUEUE_SLOTS-1 entries
// at most). One word is taken per clock while input ready is high; every
// word yields one result word, which passes the stage register (state update
// and registered ram read) and then a two-entry output buffer. All
// scalar state is updated in the cycle a word is accepted and the ram is
// written or read at that same edge, so a word never waits on the one before
// it. Input ready only drops while the stage register and the output buffer
// are both full, i.e. under back pressure on the result side. Configuration
// writes are always ready and should be issued only while no word is in
// flight; indexes beyond the register list are ignored.
module photo_position_tracker_core import ppt_pkg::*; #(
    parameter int QUEUE_SLOTS = PPT_QUEUE_SLOTS
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    ppt_item_if.sink     i_item,
    ppt_result_if.source o_result,
    ppt_cfg_if.sink      i_cfg
);

    localparam int PW = $clog2(QUEUE_SLOTS);
    localparam int FW = (PW > W_QCNT) ? PW : W_QCNT;

    typedef logic [PW-1:0] t_ptr;

    // configuration registers
    logic [W_FILT-1:0] r_count_filter;
    logic [W_FILT-1:0] r_reset_filter;
    logic [W_LOCK-1:0] r_lockout_ticks;
    logic [W_POS-1:0]  r_max_position;
    logic              r_system_enable;

    // tracker state
    t_deb              r_rst_deb, n_rst_deb;
    t_deb              r_cnt_deb, n_cnt_deb;
    logic [W_LOCK-1:0] r_lockout, n_lockout;
    logic [W_POS-1:0]  r_since, n_since;
    logic [W_POS-1:0]  r_pos, n_pos;
    logic              r_homed, n_homed;
    logic [W_POS-1:0]  r_lost, n_lost;
    t_ptr              r_head, n_head;
    t_ptr              r_tail, n_tail;

    // stage register between the update and the output buffer
    logic              r_s1_valid, n_s1_valid;
    t_result           r_s1, n_s1;

    // two-entry output buffer
    t_result           r_fifo [2];
    logic              r_wr_ptr;
    logic              r_rd_ptr;
    logic [1:0]        r_fifo_cnt;

    // ram interface
    logic              ram_we;
    logic              ram_re;
    logic [2*W_POS-1:0] ram_wdata;
    logic [2*W_POS-1:0] ram_rdata;

    logic              in_acc;
    logic              fifo_full;
    logic              s1_move;
    logic              out_pop;
    logic              push_ok;
    logic              dropped;
    t_deb_out          rst_step;
    t_deb_out          cnt_step;
    t_ptr              tail_next;
    logic [FW-1:0]     fill;
    t_result           s1_full;

    function automatic t_ptr ptr_inc(t_ptr p);
        t_ptr q;
        q = (p == t_ptr'(QUEUE_SLOTS - 1)) ? '0 : t_ptr'(p + t_ptr'(1));
        return q;
    endfunction

    // one debounce tick; rise flags an accepted rising edge
    function automatic t_deb_out deb_step(t_deb d, logic pin, logic [W_FILT-1:0] filt);
        t_deb_out          r;
        logic [W_CONF-1:0] conf;
        r      = '0;
        r.st   = d;
        r.rise = 1'b0;
        conf   = '0;
        if (d.stable != pin && d.confirm == '0) begin
            r.st.candidate = pin;
        end
        if (r.st.candidate == pin && r.st.candidate != d.stable) begin
            conf = d.confirm + W_CONF'(1);
            r.st.confirm = conf;
            if (conf > {1'b0, filt}) begin
                r.st.stable  = r.st.candidate;
                r.st.confirm = '0;
                if (r.st.candidate) begin
                    r.rise = 1'b1;
                end else begin
                    r.st.high = '0;
                end
            end
        end else begin
            r.st.candidate = d.stable;
            r.st.confirm   = '0;
        end
        if (r.st.stable) begin
            if (r.st.high >= HIGH_TIME_MAX - W_HIGH'(1)) begin
                r.st.high = HIGH_TIME_MAX;
            end else begin
                r.st.high = r.st.high + W_HIGH'(1);
            end
        end
        return r;
    endfunction

    // handshakes
    assign fifo_full      = (r_fifo_cnt == 2'd2);
    assign s1_move        = r_s1_valid && !fifo_full;
    assign i_item.ready   = !r_s1_valid || !fifo_full;
    assign in_acc         = i_item.valid && i_item.ready;
    assign o_result.valid = (r_fifo_cnt != 2'd0);
    assign out_pop        = o_result.valid && o_result.ready;
    assign i_cfg.ready    = 1'b1;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count_filter  <= W_FILT'(2);
            r_reset_filter  <= W_FILT'(5);
            r_lockout_ticks <= W_LOCK'(50);
            r_max_position  <= '0;
            r_system_enable <= 1'b0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_COUNT_FILTER:  r_count_filter  <= i_cfg.data[W_FILT-1:0];
                CFG_RESET_FILTER:  r_reset_filter  <= i_cfg.data[W_FILT-1:0];
                CFG_LOCKOUT_TICKS: r_lockout_ticks <= i_cfg.data[W_LOCK-1:0];
                CFG_MAX_POSITION:  r_max_position  <= i_cfg.data[W_POS-1:0];
                CFG_SYSTEM_ENABLE: r_system_enable <= i_cfg.data[0];
                default: begin
                end
            endcase
        end
    end

    // per-word state update, ram write on push and ram read on pop
    always_comb begin
        n_rst_deb = r_rst_deb;
        n_cnt_deb = r_cnt_deb;
        n_lockout = r_lockout;
        n_since   = r_since;
        n_pos     = r_pos;
        n_homed   = r_homed;
        n_lost    = r_lost;
        n_head    = r_head;
        n_tail    = r_tail;
        ram_re    = 1'b0;
        ram_we    = 1'b0;
        push_ok   = 1'b0;
        dropped   = 1'b0;
        tail_next = ptr_inc(r_tail);
        rst_step  = deb_step(r_rst_deb, i_item.reset_pin, r_reset_filter);
        cnt_step  = deb_step(r_cnt_deb, i_item.count_pin, r_count_filter);
        if (in_acc) begin
            if (i_item.kind) begin
                // pop: pointer moves first, then the slot it lands on is read
                if (r_head != r_tail) begin
                    n_head = ptr_inc(r_head);
                    ram_re = 1'b1;
                end
            end else begin
                n_since = r_since + W_POS'(1);
                if (r_lockout != '0) begin
                    n_lockout = r_lockout - W_LOCK'(1);
                end
                n_rst_deb = rst_step.st;
                if (rst_step.rise) begin
                    n_homed = 1'b1;
                    n_pos   = '0;
                    n_lost  = '0;
                end
                n_cnt_deb = cnt_step.st;
                if (cnt_step.rise && n_lockout == '0) begin
                    n_lockout = r_lockout_ticks;
                    n_pos     = n_pos + W_POS'(1);
                    if (tail_next == r_head) begin
                        dropped = 1'b1;
                    end else begin
                        n_tail  = tail_next;
                        ram_we  = 1'b1;
                        push_ok = 1'b1;
                    end
                    if (n_pos > r_max_position && r_system_enable) begin
                        n_lost = n_lost + W_POS'(1);
                    end
                end
            end
        end
    end

    // interval includes the current tick, written before since_last clears
    assign ram_wdata = {n_since, n_pos};

    ppt_ram #(
        .WIDTH (2 * W_POS),
        .DEPTH (QUEUE_SLOTS)
    ) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (n_tail),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (n_head),
        .o_rdata (ram_rdata)
    );

    // fill level after this word, masked to the field width
    always_comb begin
        if (n_tail >= n_head) begin
            fill = FW'(n_tail) - FW'(n_head);
        end else begin
            fill = FW'(n_tail) + FW'(QUEUE_SLOTS) - FW'(n_head);
        end
    end

    // result fields known at accept time; entry data follows from the ram
    always_comb begin
        n_s1                 = '0;
        n_s1.entry_valid     = ram_re;
        n_s1.position        = (cnt_step.rise && push_ok) ? n_pos : n_pos;
        n_s1.homed           = n_homed;
        n_s1.lost_resets     = n_lost;
        n_s1.reset_high_time = n_rst_deb.high;
        n_s1.count_high_time = n_cnt_deb.high;
        n_s1.dropped         = dropped;
        n_s1.queue_count     = fill[W_QCNT-1:0];
    end

    always_comb begin
        if (in_acc) begin
            n_s1_valid = 1'b1;
        end else if (s1_move) begin
            n_s1_valid = 1'b0;
        end else begin
            n_s1_valid = r_s1_valid;
        end
    end

    always_comb begin
        s1_full = r_s1;
        if (r_s1.entry_valid) begin
            s1_full.entry_position = ram_rdata[W_POS-1:0];
            s1_full.entry_interval = ram_rdata[2*W_POS-1:W_POS];
        end else begin
            s1_full.entry_position = '0;
            s1_full.entry_interval = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rst_deb  <= '0;
            r_cnt_deb  <= '0;
            r_lockout  <= '0;
            r_since    <= '0;
            r_pos      <= '0;
            r_homed    <= 1'b0;
            r_lost     <= '0;
            r_head     <= '0;
            r_tail     <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_rst_deb  <= n_rst_deb;
            r_cnt_deb  <= n_cnt_deb;
            r_lockout  <= n_lockout;
            r_since    <= (cnt_step.rise && n_lockout == r_lockout_ticks && in_acc
                           && !i_item.kind && (push_ok || dropped)) ? '0 : n_since;
            r_pos      <= n_pos;
            r_homed    <= n_homed;
            r_lost     <= n_lost;
            r_head     <= n_head;
            r_tail     <= n_tail;
            r_s1_valid <= n_s1_valid;
        end
    end

    // stage payload, held while the output buffer is full
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1 <= n_s1;
        end
    end

    // output buffer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr   <= 1'b0;
            r_rd_ptr   <= 1'b0;
            r_fifo_cnt <= 2'd0;
        end else begin
            if (s1_move) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (out_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_fifo_cnt <= r_fifo_cnt + 2'(s1_move) - 2'(out_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_fifo[r_wr_ptr] <= s1_full;
        end
    end

    assign o_result.entry_valid     = r_fifo[r_rd_ptr].entry_valid;
    assign o_result.entry_position  = r_fifo[r_rd_ptr].entry_position;
    assign o_result.entry_interval  = r_fifo[r_rd_ptr].entry_interval;
    assign o_result.position        = r_fifo[r_rd_ptr].position;
    assign o_result.homed           = r_fifo[r_rd_ptr].homed;
    assign o_result.lost_resets     = r_fifo[r_rd_ptr].lost_resets;
    assign o_result.reset_high_time = r_fifo[r_rd_ptr].reset_high_time;
    assign o_result.count_high_time = r_fifo[r_rd_ptr].count_high_time;
    assign o_result.dropped         = r_fifo[r_rd_ptr].dropped;
    assign o_result.queue_count     = r_fifo[r_rd_ptr].queue_count;

    // checks

    // buffer never overfills: the stage holds while both entries are taken
    `ASSERT_NEVER(a_fifo_over, i_clk, i_rst_n, r_fifo_cnt == 2'd3, "output buffer overflow")

    // once homed, only reset clears it
    `ASSERT_CLK(a_homed_sticky, i_clk, i_rst_n, r_homed |=> r_homed, "homed flag cleared")

    // a held stage word keeps its ram data: no new read while it waits
    `ASSERT_CLK(a_s1_hold, i_clk, i_rst_n, (r_s1_valid && fifo_full) |-> !ram_re,
                "ram read while stage word waits")

    // high-time counters stay within their saturation limit
    `ASSERT_NEVER(a_high_sat, i_clk, i_rst_n,
                  r_rst_deb.high > HIGH_TIME_MAX || r_cnt_deb.high > HIGH_TIME_MAX,
                  "high-time counter above limit")

endmodule

`default_nettype wire

@@ tb/sv/photo_position_tracker_core_test.sv @@
`timescale 1ns / 1ps
// self-checking test of photo_position_tracker_core: tick and read words are mirrored
// by a tracker twin class and every result word is compared field by field
// depends on ppt_pkg, ppt_ifs and the rtl of photo_position_tracker_core

module photo_position_tracker_core_test;
    import ppt_pkg::*;

    // word kinds on the item channel
    localparam logic KIND_TICK = 1'b0;
    localparam logic KIND_READ = 1'b1;

    // twin of the tracker: own copy of registers, sensor filters, counters and queue
    class tracker_twin;
        logic [W_FILT-1:0] count_filter  = 8'd2;
        logic [W_FILT-1:0] reset_filter  = 8'd5;
        logic [W_LOCK-1:0] lockout_ticks = 10'd50;
        logic [W_POS-1:0]  max_position  = 16'd0;
        logic              system_enable = 1'b0;

        t_deb              reset_sens    = '0;
        t_deb              count_sens    = '0;
        logic [W_LOCK-1:0] lockout_left  = '0;
        logic [W_POS-1:0]  since_last    = '0;
        logic [W_POS-1:0]  position      = '0;
        logic              homed         = 1'b0;
        logic [W_POS-1:0]  lost          = '0;
        logic [31:0]       marks [PPT_QUEUE_SLOTS];
        int                head          = 0;
        int                tail          = 0;

        t_result           owed_words [$];
        int                errors        = 0;

        function void write_reg(t_cfg_idx idx, logic [W_CDATA-1:0] data);
            case (idx)
                CFG_COUNT_FILTER:  count_filter  = data[W_FILT-1:0];
                CFG_RESET_FILTER:  reset_filter  = data[W_FILT-1:0];
                CFG_LOCKOUT_TICKS: lockout_ticks = data[W_LOCK-1:0];
                CFG_MAX_POSITION:  max_position  = data[W_POS-1:0];
                CFG_SYSTEM_ENABLE: system_enable = data[0];
                default: ;
            endcase
        endfunction

        // one debounce step; returns 1 on an accepted rising level
        function logic settle(inout t_deb d, input logic pin, input logic [W_FILT-1:0] filter);
            logic rise;
            rise = 1'b0;
            if (d.stable != pin && d.confirm == '0)
                d.candidate = pin;
            if (d.candidate == pin && d.candidate != d.stable) begin
                d.confirm = d.confirm + 9'd1;
                if (d.confirm > {1'b0, filter}) begin
                    d.stable  = d.candidate;
                    d.confirm = '0;
                    if (d.stable)
                        rise = 1'b1;
                    else
                        d.high = '0;
                end
            end else begin
                d.candidate = d.stable;
                d.confirm   = '0;
            end
            if (d.stable && d.high < HIGH_TIME_MAX)
                d.high = d.high + 13'd1;
            return rise;
        endfunction

        function void note_word(logic kind, logic rpin, logic cpin);
            t_result r;
            logic    reset_rise;
            logic    count_rise;
            int      nxt;
            r = '0;
            if (kind == KIND_READ) begin
                if (head != tail) begin
                    head             = (head + 1) % PPT_QUEUE_SLOTS;
                    r.entry_valid    = 1'b1;
                    r.entry_position = marks[head][15:0];
                    r.entry_interval = marks[head][31:16];
                end
            end else begin
                since_last = since_last + 16'd1;
                if (lockout_left != '0)
                    lockout_left = lockout_left - 10'd1;
                reset_rise = settle(reset_sens, rpin, reset_filter);
                if (reset_rise) begin
                    homed    = 1'b1;
                    position = '0;
                    lost     = '0;
                end
                count_rise = settle(count_sens, cpin, count_filter);
                if (count_rise && lockout_left == '0) begin
                    lockout_left = lockout_ticks;
                    position     = position + 16'd1;
                    nxt          = (tail + 1) % PPT_QUEUE_SLOTS;
                    if (nxt == head) begin
                        r.dropped = 1'b1;
                    end else begin
                        tail        = nxt;
                        marks[tail] = {since_last, position};
                    end
                    since_last = '0;
                    if (position > max_position && system_enable)
                        lost = lost + 16'd1;
                end
            end
            r.position        = position;
            r.homed           = homed;
            r.lost_resets     = lost;
            r.reset_high_time = reset_sens.high;
            r.count_high_time = count_sens.high;
            r.queue_count     = W_QCNT'((tail + PPT_QUEUE_SLOTS - head) % PPT_QUEUE_SLOTS);
            owed_words.push_back(r);
        endfunction

        function int pending();
            return owed_words.size();
        endfunction

        function void same(string field, int unsigned want, int unsigned got);
            if (want != got) begin
                $error("%s: expected %0d, actual %0d", field, want, got);
                errors++;
            end
        endfunction

        function void check_word(t_result got);
            t_result want;
            if (owed_words.size() == 0) begin
                $error("result word arrived with no expectation waiting");
                errors++;
                return;
            end
            want = owed_words.pop_front();
            same("entry_valid", want.entry_valid, got.entry_valid);
            same("entry_position", want.entry_position, got.entry_position);
            same("entry_interval", want.entry_interval, got.entry_interval);
            same("position", want.position, got.position);
            same("homed", want.homed, got.homed);
            same("lost_resets", want.lost_resets, got.lost_resets);
            same("reset_high_time", want.reset_high_time, got.reset_high_time);
            same("count_high_time", want.count_high_time, got.count_high_time);
            same("dropped", want.dropped, got.dropped);
            same("queue_count", want.queue_count, got.queue_count);
        endfunction
    endclass

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    ppt_item_if   item_ch ();
    ppt_result_if result_ch ();
    ppt_cfg_if    cfg_ch ();

    photo_position_tracker_core dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_ch),
        .o_result (result_ch),
        .i_cfg    (cfg_ch)
    );

    tracker_twin twin = new();

    // stall rates in percent for the sender and the receiver
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    // filters in use, so random sensor waveforms can straddle them
    int cur_count_filter = 2;
    int cur_reset_filter = 5;

    // intended sensor levels and ticks left before each one toggles
    logic r_level = 1'b0;
    logic c_level = 1'b0;
    int   r_hold  = 40;
    int   c_hold  = 0;

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // receiver side: random back pressure on the result channel
    initial begin
        result_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // result monitor: every accepted result word goes to the twin
    always @(posedge i_clk) begin
        t_result got;
        if (i_rst_n && result_ch.valid && result_ch.ready) begin
            got.entry_valid     = result_ch.entry_valid;
            got.entry_position  = result_ch.entry_position;
            got.entry_interval  = result_ch.entry_interval;
            got.position        = result_ch.position;
            got.homed           = result_ch.homed;
            got.lost_resets     = result_ch.lost_resets;
            got.reset_high_time = result_ch.reset_high_time;
            got.count_high_time = result_ch.count_high_time;
            got.dropped         = result_ch.dropped;
            got.queue_count     = result_ch.queue_count;
            twin.check_word(got);
        end
    end

    // hard stop well past the slowest correct run
    initial begin
        #(10_000_000);
        $display("photo_position_tracker_core_test failed");
        $finish;
    end

    // one item word; valid stays high when the next word follows at once
    task automatic send_item(input logic kind, input logic rpin, input logic cpin);
        while ($urandom_range(99) < send_idle_pct) begin
            item_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        item_ch.valid     <= 1'b1;
        item_ch.kind      <= kind;
        item_ch.reset_pin <= rpin;
        item_ch.count_pin <= cpin;
        @(posedge i_clk);
        while (!item_ch.ready)
            @(posedge i_clk);
        twin.note_word(kind, rpin, cpin);
    endtask

    task automatic send_ticks(input int n, input logic rpin, input logic cpin);
        for (int k = 0; k < n; k++)
            send_item(KIND_TICK, rpin, cpin);
    endtask

    // reads carry random pins, which the block ignores
    task automatic send_reads(input int n);
        for (int k = 0; k < n; k++)
            send_item(KIND_READ, 1'($urandom_range(1)), 1'($urandom_range(1)));
    endtask

    // sender holds off until every owed result word has come back
    task automatic drain_results();
        item_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (twin.pending() != 0)
            @(posedge i_clk);
    endtask

    // all five registers in a row, valid dropped only after the last one
    task automatic set_config(input int cnt_f, input int rst_f, input int lock,
                              input int maxp, input int en);
        t_cfg_idx           idxs [5];
        logic [W_CDATA-1:0] vals [5];
        idxs = '{CFG_COUNT_FILTER, CFG_RESET_FILTER, CFG_LOCKOUT_TICKS,
                 CFG_MAX_POSITION, CFG_SYSTEM_ENABLE};
        vals = '{W_CDATA'(cnt_f), W_CDATA'(rst_f), W_CDATA'(lock),
                 W_CDATA'(maxp), W_CDATA'(en)};
        for (int k = 0; k < 5; k++) begin
            cfg_ch.valid <= 1'b1;
            cfg_ch.index <= idxs[k];
            cfg_ch.data  <= vals[k];
            @(posedge i_clk);
            while (!cfg_ch.ready)
                @(posedge i_clk);
            twin.write_reg(idxs[k], vals[k]);
        end
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
        cur_count_filter = cnt_f;
        cur_reset_filter = rst_f;
    endtask

    // level hold: mostly long enough to pass the filter, sometimes a broken short pulse
    function automatic int hold_len(input int filter, input int spread);
        if (filter > 0 && $urandom_range(99) < 15)
            return $urandom_range(filter, 1);
        return filter + 1 + $urandom_range(spread);
    endfunction

    // random sensor waveform with reads mixed in; reset laps run longer than count marks
    task automatic run_waveform(input int n_items, input int read_pct, input int spread);
        logic rp;
        logic cp;
        for (int n = 0; n < n_items; n++) begin
            if ($urandom_range(99) < read_pct) begin
                send_reads(1);
            end else begin
                if (r_hold == 0) begin
                    r_level = !r_level;
                    r_hold  = hold_len(cur_reset_filter, r_level ? spread : spread * 12);
                end
                if (c_hold == 0) begin
                    c_level = !c_level;
                    c_hold  = hold_len(cur_count_filter, spread);
                end
                r_hold--;
                c_hold--;
                // occasional single-tick noise on either sensor
                rp = r_level ^ ($urandom_range(99) < 2);
                cp = c_level ^ ($urandom_range(99) < 2);
                send_item(KIND_TICK, rp, cp);
            end
            if ($urandom_range(299) == 0)
                drain_results();
        end
        drain_results();
    endtask

    initial begin
        item_ch.valid     = 1'b0;
        item_ch.kind      = KIND_TICK;
        item_ch.reset_pin = 1'b0;
        item_ch.count_pin = 1'b0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.index      = CFG_COUNT_FILTER;
        cfg_ch.data       = '0;

        send_idle_pct = 21;
        recv_idle_pct = 62;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed words at the reset register values
        // read of an empty queue, pins high but ignored
        send_item(KIND_READ, 1'b1, 1'b1);
        // count level held past the filter: first mark pushed
        send_ticks(4, 1'b0, 1'b1);
        // low glitch shorter than the filter, stable level stays high
        send_ticks(1, 1'b0, 1'b0);
        send_ticks(1, 1'b0, 1'b1);
        // pop the mark, then read the empty queue again
        send_item(KIND_READ, 1'b0, 1'b0);
        send_item(KIND_READ, 1'b1, 1'b0);
        // reset edge: homed set, position and lost count cleared
        send_ticks(7, 1'b1, 1'b1);
        // both sensors fall, high-time counters clear
        send_ticks(7, 1'b0, 1'b0);
        drain_results();

        run_waveform(150, 15, 6);

        // zero filters and lockout, small lap, lost-reset counting on, few reads so drops occur
        set_config(0, 0, 0, 3, 1);
        run_waveform(150, 4, 3);

        send_idle_pct = 62;
        recv_idle_pct = 21;

        // register maxima: widest filters and lockout, largest lap
        set_config(255, 255, 1023, 65535, 1);
        run_waveform(700, 2, 20);

        set_config($urandom_range(6), $urandom_range(10), $urandom_range(30),
                   $urandom_range(40), $urandom_range(1));
        run_waveform(75, 20, 8);

        send_idle_pct = 0;
        recv_idle_pct = 0;

        set_config($urandom_range(6), $urandom_range(10), $urandom_range(30),
                   $urandom_range(40), $urandom_range(1));
        run_waveform(75, 10, 8);

        // settle time for any stray result word
        repeat (20) @(posedge i_clk);
        if (twin.errors == 0) begin
            $display("photo_position_tracker_core_test passed");
        end else begin
            $display("photo_position_tracker_core_test failed");
        end
        $finish;
    end

endmodule
